// File: hdl/amf0_pkg.sv
// Package: types, codes and constants of the AMF0 stream tokeniser.
`timescale 1ns / 1ps
`default_nettype none
package amf0_pkg;

    localparam int MaxDepthDefault = 32;

    // Type markers
    localparam logic [7:0] MK_NUMBER  = 8'h00;
    localparam logic [7:0] MK_BOOLEAN = 8'h01;
    localparam logic [7:0] MK_STRING  = 8'h02;
    localparam logic [7:0] MK_OBJECT  = 8'h03;
    localparam logic [7:0] MK_NULL    = 8'h05;
    localparam logic [7:0] MK_ECMA    = 8'h08;
    localparam logic [7:0] MK_OBJEND  = 8'h09;

    // Token codes
    localparam logic [3:0] EV_BUSY     = 4'd0;
    localparam logic [3:0] EV_NUMBER   = 4'd1;
    localparam logic [3:0] EV_BOOLEAN  = 4'd2;
    localparam logic [3:0] EV_NULL     = 4'd3;
    localparam logic [3:0] EV_STRLEN   = 4'd4;
    localparam logic [3:0] EV_STRBYTE  = 4'd5;
    localparam logic [3:0] EV_OBJOPEN  = 4'd6;
    localparam logic [3:0] EV_ECMAOPEN = 4'd7;
    localparam logic [3:0] EV_OBJCLOSE = 4'd8;
    localparam logic [3:0] EV_KEYLEN   = 4'd9;
    localparam logic [3:0] EV_KEYBYTE  = 4'd10;
    localparam logic [3:0] EV_ERROR    = 4'd11;

    // Error codes
    localparam logic [3:0] ERR_NONE          = 4'd0;
    localparam logic [3:0] ERR_NUM_TRUNC     = 4'd1;
    localparam logic [3:0] ERR_BOOL_TRUNC    = 4'd2;
    localparam logic [3:0] ERR_LEN_TRUNC     = 4'd3;
    localparam logic [3:0] ERR_PAYLOAD_TRUNC = 4'd4;
    localparam logic [3:0] ERR_ECMA_TRUNC    = 4'd5;
    localparam logic [3:0] ERR_BAD_MARKER    = 4'd6;
    localparam logic [3:0] ERR_EMPTY_PROP    = 4'd7;
    localparam logic [3:0] ERR_NO_END        = 4'd8;
    localparam logic [3:0] ERR_DEPTH         = 4'd9;

    typedef enum logic [3:0] {
        PH_TOP      = 4'd0,
        PH_KEYHI    = 4'd1,
        PH_KEYLO    = 4'd2,
        PH_KEYBYTES = 4'd3,
        PH_VALMARK  = 4'd4,
        PH_NUM      = 4'd5,
        PH_BOOL     = 4'd6,
        PH_STRHI    = 4'd7,
        PH_STRLO    = 4'd8,
        PH_STRBYTES = 4'd9,
        PH_ECMA     = 4'd10,
        PH_IDLE     = 4'd11
    } phase_t;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last;
    } amf0_in_t;

    typedef struct packed {
        logic [3:0]  event_res;
        logic [63:0] value_data;
        logic [5:0]  nest_depth;
        logic [3:0]  error_code;
        logic        value_done;
    } amf0_out_t;

endpackage
`default_nettype wire

// File: hdl/amf0_stream_tokenizer_unit.sv
// Top level: AMF0 stream tokeniser, one token per message byte.
// A byte's token is registered and appears at the output in the cycle after the byte's transfer.
// Throughput: one byte per cycle while the output is not stalled; all per-byte work is a single pass from the
// parse state registers to the result register.
// Back-pressure: in_ready drops only while a token waits and out_ready is low.
// Reset (rst_n low, asynchronous): expect a top-level marker, depth zero, output empty.
// The same parse state clears after every byte flagged as last; the output is not emptied then.
`timescale 1ns / 1ps
`default_nettype none
module amf0_stream_tokenizer_unit #(
    parameter int MAX_DEPTH = amf0_pkg::MaxDepthDefault
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire amf0_pkg::amf0_in_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output amf0_pkg::amf0_out_t     out_data
);
    import amf0_pkg::*;

    localparam logic [5:0] DepthLimit = 6'(MAX_DEPTH);

    // Parse state
    phase_t      phase_reg, phase_next;
    logic [15:0] count_reg, count_next;    // payload bytes left, or bytes taken of a number/count
    logic [63:0] asm_reg,   asm_next;      // number/count assembly, length high byte
    logic [5:0]  depth_reg, depth_next;
    logic        kwe_reg,   kwe_next;      // previous key was empty

    // Result register
    logic      out_valid_reg;
    amf0_out_t out_data_reg;
    amf0_out_t result;

    logic        accept;
    logic [7:0]  b;
    logic        last;
    logic [63:0] asm_shift;
    logic [15:0] count_inc;
    logic [15:0] count_dec;
    logic [15:0] len;
    logic        take_marker;
    logic        complete;
    logic [3:0]  ev;
    logic [3:0]  err;
    logic [63:0] val;
    logic        done;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign b         = in_data.byte_in;
    assign last      = in_data.last;
    assign asm_shift = {asm_reg[55:0], b};
    assign count_inc = count_reg + 16'd1;
    assign count_dec = count_reg - 16'd1;
    assign len       = {asm_reg[7:0], b};

    // Next state and token for the byte at the input
    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        asm_next    = asm_reg;
        depth_next  = depth_reg;
        kwe_next    = kwe_reg;
        ev          = EV_BUSY;
        err         = ERR_NONE;
        val         = 64'd0;
        done        = 1'b0;
        take_marker = 1'b0;
        complete    = 1'b0;

        case (phase_reg)
            PH_TOP:
            begin
                take_marker = 1'b1;
            end
            PH_VALMARK:
            begin
                kwe_next = 1'b0;
                if (kwe_reg && b == MK_OBJEND)
                begin
                    if (depth_reg != 6'd0)
                    begin
                        depth_next = depth_reg - 6'd1;
                    end
                    ev       = EV_OBJCLOSE;
                    complete = 1'b1;
                end
                else
                begin
                    take_marker = 1'b1;
                end
            end
            PH_KEYHI:
            begin
                asm_next   = {56'd0, b};
                phase_next = PH_KEYLO;
                err        = last ? ERR_LEN_TRUNC : ERR_NONE;
            end
            PH_STRHI:
            begin
                asm_next   = {56'd0, b};
                phase_next = PH_STRLO;
                err        = last ? ERR_LEN_TRUNC : ERR_NONE;
            end
            PH_KEYLO:
            begin
                ev  = EV_KEYLEN;
                val = {48'd0, len};
                if (len == 16'd0)
                begin
                    kwe_next   = 1'b1;
                    phase_next = PH_VALMARK;
                    err        = last ? ERR_EMPTY_PROP : ERR_NONE;
                end
                else
                begin
                    kwe_next   = 1'b0;
                    count_next = len;
                    phase_next = PH_KEYBYTES;
                    err        = last ? ERR_PAYLOAD_TRUNC : ERR_NONE;
                end
            end
            PH_KEYBYTES:
            begin
                ev         = EV_KEYBYTE;
                val        = {56'd0, b};
                count_next = count_dec;
                if (count_dec == 16'd0)
                begin
                    phase_next = PH_VALMARK;
                    err        = last ? ERR_EMPTY_PROP : ERR_NONE;
                end
                else
                begin
                    err = last ? ERR_PAYLOAD_TRUNC : ERR_NONE;
                end
            end
            PH_STRLO:
            begin
                ev  = EV_STRLEN;
                val = {48'd0, len};
                if (len == 16'd0)
                begin
                    complete = 1'b1;
                end
                else
                begin
                    count_next = len;
                    phase_next = PH_STRBYTES;
                    err        = last ? ERR_PAYLOAD_TRUNC : ERR_NONE;
                end
            end
            PH_STRBYTES:
            begin
                ev         = EV_STRBYTE;
                val        = {56'd0, b};
                count_next = count_dec;
                if (count_dec == 16'd0)
                begin
                    complete = 1'b1;
                end
                else
                begin
                    err = last ? ERR_PAYLOAD_TRUNC : ERR_NONE;
                end
            end
            PH_NUM:
            begin
                asm_next   = asm_shift;
                count_next = count_inc;
                if (count_inc >= 16'd8)
                begin
                    ev       = EV_NUMBER;
                    val      = asm_shift;
                    complete = 1'b1;
                end
                else
                begin
                    err = last ? ERR_NUM_TRUNC : ERR_NONE;
                end
            end
            PH_BOOL:
            begin
                ev       = EV_BOOLEAN;
                val      = {63'd0, (b != 8'd0)};
                complete = 1'b1;
            end
            PH_ECMA:
            begin
                asm_next   = {32'd0, asm_shift[31:0]};
                count_next = count_inc;
                if (count_inc >= 16'd4)
                begin
                    if (depth_reg >= DepthLimit)
                    begin
                        err = ERR_DEPTH;
                    end
                    else
                    begin
                        depth_next = depth_reg + 6'd1;
                        ev         = EV_ECMAOPEN;
                        val        = {32'd0, asm_shift[31:0]};
                        phase_next = PH_KEYHI;
                        err        = last ? ERR_NO_END : ERR_NONE;
                    end
                end
                else
                begin
                    err = last ? ERR_ECMA_TRUNC : ERR_NONE;
                end
            end
            default:
            begin
                // idle until the last byte
            end
        endcase

        // Type marker at the top level or at a property value
        if (take_marker)
        begin
            case (b)
                MK_NUMBER:
                begin
                    phase_next = PH_NUM;
                    count_next = 16'd0;
                    asm_next   = 64'd0;
                    err        = last ? ERR_NUM_TRUNC : ERR_NONE;
                end
                MK_BOOLEAN:
                begin
                    phase_next = PH_BOOL;
                    err        = last ? ERR_BOOL_TRUNC : ERR_NONE;
                end
                MK_STRING:
                begin
                    phase_next = PH_STRHI;
                    err        = last ? ERR_LEN_TRUNC : ERR_NONE;
                end
                MK_OBJECT:
                begin
                    if (depth_reg >= DepthLimit)
                    begin
                        err = ERR_DEPTH;
                    end
                    else
                    begin
                        depth_next = depth_reg + 6'd1;
                        ev         = EV_OBJOPEN;
                        phase_next = PH_KEYHI;
                        err        = last ? ERR_NO_END : ERR_NONE;
                    end
                end
                MK_NULL:
                begin
                    ev       = EV_NULL;
                    complete = 1'b1;
                end
                MK_ECMA:
                begin
                    phase_next = PH_ECMA;
                    count_next = 16'd0;
                    asm_next   = 64'd0;
                    err        = last ? ERR_ECMA_TRUNC : ERR_NONE;
                end
                default:
                begin
                    err = ERR_BAD_MARKER;
                end
            endcase
        end

        // Value finished: back to top level or on to the next key
        if (complete)
        begin
            if (depth_next == 6'd0)
            begin
                done       = 1'b1;
                phase_next = PH_TOP;
            end
            else
            begin
                phase_next = PH_KEYHI;
                err        = last ? ERR_NO_END : ERR_NONE;
            end
        end

        // An error replaces the token and parks the parser
        if (err != ERR_NONE)
        begin
            ev         = EV_ERROR;
            val        = 64'd0;
            done       = 1'b0;
            phase_next = PH_IDLE;
        end

        result.event_res  = ev;
        result.value_data = val;
        result.nest_depth = depth_next;
        result.error_code = err;
        result.value_done = done;

        // End of message: clear all parse state
        if (last)
        begin
            phase_next = PH_TOP;
            count_next = 16'd0;
            asm_next   = 64'd0;
            depth_next = 6'd0;
            kwe_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_TOP;
            count_reg     <= 16'd0;
            asm_reg       <= 64'd0;
            depth_reg     <= 6'd0;
            kwe_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            asm_reg       <= asm_next;
            depth_reg     <= depth_next;
            kwe_reg       <= kwe_next;
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Token payload: loaded on every input transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= result;
        end
    end

    // Error token and error code always go together
    a_err_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            ((out_data_reg.event_res == EV_ERROR) == (out_data_reg.error_code != ERR_NONE)))
        else $error("error token and error code disagree");

    // A top-level value only completes outside any object
    a_done_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.value_done) |-> (out_data_reg.nest_depth == 6'd0))
        else $error("value completed inside an object");

    // Nesting never exceeds the limit
    a_depth_limit: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DepthLimit)
        else $error("nesting depth above limit");

    // Last byte of a message leaves the parser cleared
    a_last_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.last) |=> (phase_reg == PH_TOP && depth_reg == 6'd0 && !kwe_reg))
        else $error("state not cleared after last byte");

endmodule
`default_nettype wire

// File: tb/amf0_stream_tokenizer_unit_tb.sv
// Testbench for the AMF0 stream tokeniser: whole messages in, every token checked against a predictor.
`timescale 1ns / 1ps
module amf0_stream_tokenizer_unit_tb;
    import amf0_pkg::*;

    localparam int DepthLimit  = MaxDepthDefault;
    localparam int ByteTarget  = 1650;    // bytes transferred into the block
    localparam int CycleLimit  = 200000;  // watchdog limit, in clock cycles
    localparam int DrainCycles = 8;
    localparam int LongHold    = 300;     // cycles of receiver hold-off on request

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    amf0_in_t  in_data;
    logic      out_valid;
    logic      out_ready;
    amf0_out_t out_data;

    amf0_stream_tokenizer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Tokens still owed by the block, oldest first.
    amf0_out_t  expected_tokens[$];
    logic [7:0] msg[$];             // message under construction
    int         fail_count    = 0;
    int         cycle_count   = 0;
    int         sent_bytes    = 0;  // bytes transferred into the block
    int         burst_left    = 0;  // transfers left in the current sender burst
    int         hold_requests = 0;  // long hold-offs asked of the receiver so far

    // ------------------------------------------------------------------
    // Parser model. Own copy of the tokeniser state, advanced once per
    // accepted byte, in transfer order.
    // ------------------------------------------------------------------
    phase_t      ps_phase;
    logic [15:0] ps_count;      // bytes left in a key/string, or bytes seen in a number/count
    logic [63:0] ps_accum;      // number, ECMA count or high length byte being assembled
    int          ps_depth;
    bit          ps_empty_key;  // last key had length zero, so 0x09 may close

    function automatic void parser_clear();
        ps_phase     = PH_TOP;
        ps_count     = '0;
        ps_accum     = '0;
        ps_depth     = 0;
        ps_empty_key = 1'b0;
    endfunction

    // A value has ended: at top level it counts as done, inside an object the
    // next thing is a key, and ending the message there leaves the object open.
    function automatic logic [3:0] value_complete(input logic lst, inout amf0_out_t t);
        if (ps_depth == 0)
        begin
            t.value_done = 1'b1;
            ps_phase     = PH_TOP;
            return ERR_NONE;
        end
        ps_phase = PH_KEYHI;
        return lst ? ERR_NO_END : ERR_NONE;
    endfunction

    // Type marker, at top level or after a key.
    function automatic logic [3:0] open_value(input logic [7:0] b, input logic lst,
                                              inout amf0_out_t t);
        case (b)
            MK_NUMBER:
            begin
                ps_phase = PH_NUM;
                ps_count = '0;
                ps_accum = '0;
                return lst ? ERR_NUM_TRUNC : ERR_NONE;
            end
            MK_BOOLEAN:
            begin
                ps_phase = PH_BOOL;
                return lst ? ERR_BOOL_TRUNC : ERR_NONE;
            end
            MK_STRING:
            begin
                ps_phase = PH_STRHI;
                return lst ? ERR_LEN_TRUNC : ERR_NONE;
            end
            MK_OBJECT:
            begin
                if (ps_depth >= DepthLimit)
                    return ERR_DEPTH;
                ps_depth++;
                t.event_res = EV_OBJOPEN;
                ps_phase    = PH_KEYHI;
                return lst ? ERR_NO_END : ERR_NONE;
            end
            MK_NULL:
            begin
                t.event_res = EV_NULL;
                return value_complete(lst, t);
            end
            MK_ECMA:
            begin
                ps_phase = PH_ECMA;
                ps_count = '0;
                ps_accum = '0;
                return lst ? ERR_ECMA_TRUNC : ERR_NONE;
            end
            default:
                return ERR_BAD_MARKER;
        endcase
    endfunction

    // Token for one byte; the model state moves on as a side effect.
    function automatic amf0_out_t predict_token(input logic [7:0] b, input logic lst);
        amf0_out_t   t;
        logic [3:0]  err;
        logic [15:0] len;
        t   = '0;
        err = ERR_NONE;
        len = {ps_accum[7:0], b};
        case (ps_phase)
            PH_TOP:
                err = open_value(b, lst, t);
            PH_VALMARK:
            begin
                if (ps_empty_key && b == MK_OBJEND)
                begin
                    ps_empty_key = 1'b0;
                    if (ps_depth > 0)
                        ps_depth--;
                    t.event_res = EV_OBJCLOSE;
                    err = value_complete(lst, t);
                end
                else
                begin
                    ps_empty_key = 1'b0;
                    err = open_value(b, lst, t);
                end
            end
            PH_KEYHI, PH_STRHI:
            begin
                ps_accum = 64'(b);
                ps_phase = (ps_phase == PH_KEYHI) ? PH_KEYLO : PH_STRLO;
                err = lst ? ERR_LEN_TRUNC : ERR_NONE;
            end
            PH_KEYLO:
            begin
                t.event_res  = EV_KEYLEN;
                t.value_data = 64'(len);
                ps_empty_key = (len == 16'd0);
                if (len == 16'd0)
                begin
                    ps_phase = PH_VALMARK;
                    err = lst ? ERR_EMPTY_PROP : ERR_NONE;
                end
                else
                begin
                    ps_count = len;
                    ps_phase = PH_KEYBYTES;
                    err = lst ? ERR_PAYLOAD_TRUNC : ERR_NONE;
                end
            end
            PH_KEYBYTES:
            begin
                t.event_res  = EV_KEYBYTE;
                t.value_data = 64'(b);
                ps_count--;
                if (ps_count == 16'd0)
                begin
                    ps_phase = PH_VALMARK;
                    err = lst ? ERR_EMPTY_PROP : ERR_NONE;
                end
                else
                    err = lst ? ERR_PAYLOAD_TRUNC : ERR_NONE;
            end
            PH_STRLO:
            begin
                t.event_res  = EV_STRLEN;
                t.value_data = 64'(len);
                if (len == 16'd0)
                    err = value_complete(lst, t);
                else
                begin
                    ps_count = len;
                    ps_phase = PH_STRBYTES;
                    err = lst ? ERR_PAYLOAD_TRUNC : ERR_NONE;
                end
            end
            PH_STRBYTES:
            begin
                t.event_res  = EV_STRBYTE;
                t.value_data = 64'(b);
                ps_count--;
                if (ps_count == 16'd0)
                    err = value_complete(lst, t);
                else
                    err = lst ? ERR_PAYLOAD_TRUNC : ERR_NONE;
            end
            PH_NUM:
            begin
                ps_accum = {ps_accum[55:0], b};
                ps_count++;
                if (ps_count >= 16'd8)
                begin
                    t.event_res  = EV_NUMBER;
                    t.value_data = ps_accum;
                    err = value_complete(lst, t);
                end
                else
                    err = lst ? ERR_NUM_TRUNC : ERR_NONE;
            end
            PH_BOOL:
            begin
                t.event_res  = EV_BOOLEAN;
                t.value_data = (b != 8'd0) ? 64'd1 : 64'd0;
                err = value_complete(lst, t);
            end
            PH_ECMA:
            begin
                ps_accum = {32'd0, ps_accum[23:0], b};
                ps_count++;
                if (ps_count >= 16'd4)
                begin
                    // depth is only checked once the whole count is in
                    if (ps_depth >= DepthLimit)
                        err = ERR_DEPTH;
                    else
                    begin
                        ps_depth++;
                        t.event_res  = EV_ECMAOPEN;
                        t.value_data = ps_accum;
                        ps_phase     = PH_KEYHI;
                        err = lst ? ERR_NO_END : ERR_NONE;
                    end
                end
                else
                    err = lst ? ERR_ECMA_TRUNC : ERR_NONE;
            end
            default:
                ; // idle after an error: nothing but the depth on the output
        endcase
        // the error token takes the place of whatever the byte produced
        if (err != ERR_NONE)
        begin
            t.event_res  = EV_ERROR;
            t.value_data = '0;
            t.value_done = 1'b0;
            ps_phase     = PH_IDLE;
        end
        t.nest_depth = 6'(ps_depth);
        t.error_code = err;
        if (lst)
            parser_clear();
        return t;
    endfunction

    // Queues a predicted token behind the ones already owed.
    function automatic void owe_token(input amf0_out_t t);
        expected_tokens.insert(expected_tokens.size(), t);
    endfunction

    // ------------------------------------------------------------------
    // Message builders. All append to msg; build_nest clears it first.
    // ------------------------------------------------------------------

    function automatic void add_byte(input logic [7:0] v);
        msg.insert(msg.size(), v);
    endfunction

    // 16-bit length then that many random bytes; shared by keys and strings.
    function automatic void add_text(input int n);
        add_byte(n[15:8]);
        add_byte(n[7:0]);
        repeat (n)
            add_byte(8'($urandom_range(0, 255)));
    endfunction

    function automatic void add_close();
        add_byte(8'h00);
        add_byte(8'h00);
        add_byte(MK_OBJEND);
    endfunction

    // One well-formed value; containers only in the upper few levels so that
    // messages stay short.
    function automatic void add_value(input int lvl);
        int kind;
        int flavour;
        kind = $urandom_range(0, (lvl < 3) ? 6 : 3);
        case (kind)
            0:
            begin
                add_byte(MK_NUMBER);
                flavour = $urandom_range(0, 9);
                repeat (8)
                    add_byte((flavour == 0) ? 8'h00 :
                             (flavour == 1) ? 8'hFF : 8'($urandom_range(0, 255)));
            end
            1:
            begin
                add_byte(MK_BOOLEAN);
                add_byte(($urandom_range(0, 2) == 0) ? 8'h00 :
                         ($urandom_range(0, 1) == 0) ? 8'h01 : 8'($urandom_range(0, 255)));
            end
            2:
            begin
                add_byte(MK_STRING);
                // mostly short strings, now and then a long one
                add_text(($urandom_range(0, 99) < 3) ? $urandom_range(200, 300)
                                                     : $urandom_range(0, 8));
            end
            3:
                add_byte(MK_NULL);
            default:
            begin
                if (kind == 6)
                begin
                    add_byte(MK_ECMA);
                    repeat (4)
                        add_byte(8'($urandom_range(0, 255)));
                end
                else
                    add_byte(MK_OBJECT);
                // properties; a zero-length key before a real value is legal too
                repeat ($urandom_range(0, 3))
                begin
                    add_text($urandom_range(0, 5));
                    add_value(lvl + 1);
                end
                add_close();
            end
        endcase
    endfunction

    // Chain of nested containers, innermost marker chosen by the caller.
    function automatic void build_nest(input int levels, input logic [7:0] inner,
                                       input bit closed);
        logic [7:0] mk;
        msg.delete();
        for (int i = 1; i <= levels; i++)
        begin
            if (i > 1)
                add_text($urandom_range(0, 2));
            mk = (i == levels) ? inner
               : (($urandom_range(0, 3) == 0) ? MK_ECMA : MK_OBJECT);
            add_byte(mk);
            if (mk == MK_ECMA)
                repeat (4)
                    add_byte(8'($urandom_range(0, 255)));
        end
        if (closed)
            repeat (levels)
                add_close();
    endfunction

    // ------------------------------------------------------------------
    // Sender. Bursts of random length with random gaps; valid is only
    // lowered when a real gap follows, so it never drops and rises in the
    // same step.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic lst);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= '{byte_in: b, last: lst};
        do
            @(posedge clk);
        while (!in_ready);
        sent_bytes++;
        owe_token(predict_token(b, lst));
    endtask

    task automatic send_message(input logic [7:0] bytes[$]);
        foreach (bytes[i])
            send_byte(bytes[i], i == bytes.size() - 1);
    endtask

    // Mostly well-formed messages, plus cut-short, corrupted and noise ones.
    task automatic send_random_message();
        int pick;
        int cut;
        int idx;
        pick = $urandom_range(0, 99);
        msg.delete();
        if (pick < 3)
            build_nest($urandom_range(20, DepthLimit + 2),
                       ($urandom_range(0, 1) == 0) ? MK_ECMA : MK_OBJECT, 1'b1);
        else if (pick < 89)
            repeat ($urandom_range(1, 3))
                add_value(0);
        if (pick >= 65 && pick < 77)
        begin
            // cut short: last lands somewhere inside
            cut = $urandom_range(1, msg.size());
            while (msg.size() > cut)
                void'(msg.pop_back());
        end
        else if (pick >= 77 && pick < 89)
        begin
            // one byte replaced, often by an end marker out of place
            idx = $urandom_range(0, msg.size() - 1);
            msg[idx] = ($urandom_range(0, 1) == 0) ? MK_OBJEND : 8'($urandom_range(0, 255));
        end
        else if (pick >= 89)
        begin
            repeat ($urandom_range(1, 10))
                add_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1) == 0)
                msg[0] = 8'($urandom_range(0, 10)); // near the marker codes
        end
        send_message(msg);
    endtask

    // ------------------------------------------------------------------
    // Receiver. Own stall pattern: modes of random length, from always
    // ready to heavy stalling, plus the long hold-off on request.
    // ------------------------------------------------------------------
    initial
    begin : rx_pacing
        int mode;
        int mode_left;
        int hold_left;
        int hold_seen;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        hold_seen = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                hold_left = LongHold;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 3) != 0);
                    2:       out_ready <= ($urandom_range(0, 4) < 2);
                    default: out_ready <= (mode_left % 3 != 0);
                endcase
        end
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] wanted);
        $display("[%0t] %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, wanted);
        fail_count++;
    endtask

    // Every output transfer is compared with the oldest owed token.
    always @(posedge clk)
    begin : token_check
        amf0_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_tokens.size() == 0)
                report_mismatch("unrequested token", 64'(out_data.event_res), 64'(EV_BUSY));
            else
            begin
                want = expected_tokens.pop_front();
                if (out_data.event_res !== want.event_res)
                    report_mismatch("event_res", 64'(out_data.event_res), 64'(want.event_res));
                if (out_data.value_data !== want.value_data)
                    report_mismatch("value_data", out_data.value_data, want.value_data);
                if (out_data.nest_depth !== want.nest_depth)
                    report_mismatch("nest_depth", 64'(out_data.nest_depth),
                                    64'(want.nest_depth));
                if (out_data.error_code !== want.error_code)
                    report_mismatch("error_code", 64'(out_data.error_code),
                                    64'(want.error_code));
                if (out_data.value_done !== want.value_done)
                    report_mismatch("value_done", 64'(out_data.value_done),
                                    64'(want.value_done));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin : watchdog
        wait (cycle_count >= CycleLimit);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-written messages: each value type, field extremes, and each way a
    // message can go wrong short of nesting too deep.
    task automatic test_directed();
        // null alone, done at top level on the final byte
        send_message('{MK_NULL});
        // two numbers in one message: all zeros then all ones
        send_message('{MK_NUMBER, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                       MK_NUMBER, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        send_message('{MK_BOOLEAN, 8'hFF, MK_BOOLEAN, 8'h00});
        // empty string, then a short one
        send_message('{MK_STRING, 8'h00, 8'h00, MK_STRING, 8'h00, 8'h02, 8'h80, 8'h7F});
        // object with one property, closed at top level
        send_message('{MK_OBJECT, 8'h00, 8'h01, 8'h61, MK_NULL, 8'h00, 8'h00, MK_OBJEND});
        // ECMA array with the largest count, no properties
        send_message('{MK_ECMA, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, MK_OBJEND});
        // zero-length key followed by a real value, then the close
        send_message('{MK_ECMA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, MK_NULL,
                       8'h00, 8'h00, MK_OBJEND});
        // truncations of every kind
        send_message('{MK_NUMBER, 8'h01, 8'h02, 8'h03});
        send_message('{MK_BOOLEAN});
        send_message('{MK_STRING, 8'h00});
        send_message('{MK_STRING, 8'hFF, 8'hFF, 8'h41});   // largest length, cut short
        send_message('{MK_ECMA, 8'h00, 8'h00});
        send_message('{MK_OBJECT, 8'h00});                 // key length cut short
        // object left open: right after the open, and after a property
        send_message('{MK_OBJECT});
        send_message('{MK_OBJECT, 8'h00, 8'h01, 8'h41, MK_NULL});
        // inner close on the final byte still leaves the outer one open
        send_message('{MK_OBJECT, 8'h00, 8'h00, MK_OBJECT, 8'h00, 8'h00, MK_OBJEND});
        // message ends on a key with no value: empty key and named key
        send_message('{MK_OBJECT, 8'h00, 8'h00});
        send_message('{MK_OBJECT, 8'h00, 8'h01, 8'h41});
        // bad markers: unknown code, end marker at top, end marker after a named key
        send_message('{8'h04, 8'h55, 8'hAA});
        send_message('{MK_OBJEND});
        send_message('{MK_OBJECT, 8'h00, 8'h01, 8'h41, MK_OBJEND, 8'h00});
    endtask

    // Nesting right up to the limit and one level past it, by object and by
    // ECMA array.
    task automatic test_depth_limit();
        build_nest(DepthLimit, MK_OBJECT, 1'b1);
        send_message(msg);
        build_nest(DepthLimit + 1, MK_OBJECT, 1'b0);
        add_byte(8'h00);
        add_byte(MK_OBJEND);
        send_message(msg);
        build_nest(DepthLimit + 1, MK_ECMA, 1'b0);
        add_byte(8'h00);
        send_message(msg);
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering,
    // so the output fills and in_ready has to drop.
    task automatic test_output_stall();
        burst_left = 200;
        hold_requests++;
        repeat (6)
            send_random_message();
    endtask

    task automatic test_random_messages();
        while (sent_bytes < ByteTarget)
            send_random_message();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        parser_clear();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_depth_limit();
        test_output_stall();
        test_random_messages();
        in_valid <= 1'b0;

        // drain, then allow for a token still in flight
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (fail_count == 0 && expected_tokens.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: sim.f
hdl/amf0_pkg.sv
hdl/amf0_stream_tokenizer_unit.sv
tb/amf0_stream_tokenizer_unit_tb.sv
